>>> sv/vadpcm_pkg.sv
// Shared constants, types and helper functions for the vector-ADPCM frame decoder.
// No dependencies; imported by all decoder modules.
`default_nettype none

package vadpcm_pkg;

  localparam int MAX_PRED_DEF = 16;   // default book size in predictor entries
  localparam int COEF_W       = 16;
  localparam int SMP_W        = 16;
  localparam int PROD_W       = 2 * COEF_W;
  localparam int ACC_W        = 36;   // res<<11 plus up to nine 16x16 products
  localparam int FRAC_W       = 11;   // Q11
  localparam int Q_W          = ACC_W - FRAC_W;
  localparam int CFG_IDX_W    = 8;
  localparam int CNT_W        = 5;

  localparam logic [3:0] SHIFT_MAX = 4'd12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_COUNT = 8'd1;

  // input command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // sample format codes
  localparam logic FMT_ADPCM = 1'b0;
  localparam logic FMT_RAW   = 1'b1;

  // control that travels with each multiply term
  typedef struct packed {
    logic vld;
    logic first;   // first term of a sample: accumulator restarts from base
  } mac_ctl_t;

  // residual idx (0 = bits 63..60) scaled by 2^sh, sh <= 12
  function automatic logic signed [SMP_W-1:0] nib_res(input logic [63:0] nibs,
                                                     input logic [3:0]  idx,
                                                     input logic [3:0]  sh);
    logic [3:0]              n;
    logic signed [SMP_W-1:0] v;
    n = 4'(nibs >> (7'd60 - {1'b0, idx, 2'b00}));
    v = {{(SMP_W-4){n[3]}}, n};
    return v <<< sh;
  endfunction

  // saturate the Q11-floored accumulator to 16 bits
  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [Q_W-1:0] q);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &q[Q_W-1:SMP_W-1];
    hi_zeros = ~|q[Q_W-1:SMP_W-1];
    if (q[Q_W-1] && !hi_ones) begin
      return {1'b1, {(SMP_W-1){1'b0}}};
    end else if (!q[Q_W-1] && !hi_zeros) begin
      return {1'b0, {(SMP_W-1){1'b1}}};
    end
    return q[SMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/vadpcm_mac.sv
// Shared multiply-accumulate unit: one 16x16 product per cycle, registered,
// then accumulated. Depends on vadpcm_pkg.
`default_nettype none

module vadpcm_mac (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire vadpcm_pkg::mac_ctl_t           ctl,
  input  wire logic signed [15:0]             coef,
  input  wire logic signed [15:0]             opnd,
  input  wire logic signed [vadpcm_pkg::ACC_W-1:0] base,
  output logic signed [vadpcm_pkg::ACC_W-1:0] acc,
  output logic                                busy
);
  import vadpcm_pkg::*;

  mac_ctl_t                  ctl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_r.vld) begin
      acc_nxt = (ctl_r.first ? base : acc_r) + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * opnd;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign busy = ctl_r.vld;

endmodule

`default_nettype wire

>>> sv/vadpcm_seq.sv
// Frame sequencer: coefficient book memory, history, term issue to the shared
// MAC, saturation and the result register. Depends on vadpcm_pkg.
`default_nettype none

module vadpcm_seq #(
  parameter int MAX_PREDICTORS = vadpcm_pkg::MAX_PRED_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire logic                             sample_format,
  input  wire logic [vadpcm_pkg::CNT_W-1:0]     predictor_count,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             cmd,
  input  wire logic                             first_frame,
  input  wire logic [7:0]                       frame_header,
  input  wire logic [63:0]                      frame_nibbles,
  input  wire logic [7:0]                       coef_index,
  input  wire logic signed [15:0]               coef_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [15:0]                    out_sample,
  output logic                                  out_last,
  output logic                                  out_error,
  output vadpcm_pkg::mac_ctl_t                  mac_ctl,
  output logic signed [15:0]                    mac_coef,
  output logic signed [15:0]                    mac_opnd,
  output logic signed [vadpcm_pkg::ACC_W-1:0]   mac_base,
  input  wire logic signed [vadpcm_pkg::ACC_W-1:0] mac_acc,
  input  wire logic                             mac_busy
);
  import vadpcm_pkg::*;

  localparam int BOOK_WORDS = MAX_PREDICTORS * 16;
  localparam int AW         = $clog2(BOOK_WORDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic signed [COEF_W-1:0] book [BOOK_WORDS];

  logic [1:0]              state_r, state_nxt;
  logic [3:0]              k_r, k_nxt;       // sample index in frame
  logic [3:0]              t_r, t_nxt;       // term index in sample
  logic [3:0]              pred_r, pred_nxt;
  logic [3:0]              shift_r, shift_nxt;
  logic [63:0]             nib_r, nib_nxt;
  logic                    err_r, err_nxt;
  logic signed [SMP_W-1:0] h0_r, h0_nxt;
  logic signed [SMP_W-1:0] h1_r, h1_nxt;
  logic signed [SMP_W-1:0] dec6_r, dec6_nxt;

  logic                    out_vld_r, out_vld_nxt;
  logic signed [SMP_W-1:0] out_smp_r, out_smp_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  logic                    in_acc;
  logic                    bk_we;
  logic [AW-1:0]           bk_wa;
  logic [AW-1:0]           bk_ra;
  logic [7:0]              rd_full;
  logic [CNT_W-1:0]        limit;
  logic                    bad_pred;
  logic [3:0]              hdr_shift;
  logic [2:0]              i;
  logic [3:0]              t_last;
  logic [3:0]              dif;
  logic [2:0]              j;
  logic [3:0]              pos;
  logic signed [SMP_W-1:0] opnd;
  logic signed [SMP_W-1:0] res_k;
  logic                    issue;
  logic                    out_free;
  logic                    out_wr;
  logic                    fin_go;
  logic signed [SMP_W-1:0] dec;

  mac_ctl_t                ctl_d1_r;
  logic signed [COEF_W-1:0] coef_rd_r;
  logic signed [SMP_W-1:0] opnd_d1_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign bk_we     = in_acc && (cmd == CMD_LOAD) && ({1'b0, coef_index} < 9'(BOOK_WORDS));
  assign bk_wa     = coef_index[AW-1:0];
  assign limit     = (predictor_count > CNT_W'(MAX_PREDICTORS)) ?
                     CNT_W'(MAX_PREDICTORS) : predictor_count;
  assign bad_pred  = ({1'b0, frame_header[3:0]} >= limit);
  assign hdr_shift = (frame_header[7:4] > SHIFT_MAX) ? SHIFT_MAX : frame_header[7:4];

  // term t of sample i: t=0 c[i]*h0, t=1 c[8+i]*h1, t>=2 c[8+i-j-1]*res[j], j=t-2
  assign i      = k_r[2:0];
  assign t_last = {1'b0, i} + 4'd1;
  assign dif    = t_last - t_r;
  assign j      = 3'(t_r - 4'd2);

  always_comb begin
    if (t_r == 4'd0) begin
      pos  = {1'b0, i};
      opnd = h0_r;
    end else if (t_r == 4'd1) begin
      pos  = {1'b1, i};
      opnd = h1_r;
    end else begin
      pos  = {1'b1, dif[2:0]};
      opnd = nib_res(nib_r, {k_r[3], j}, shift_r);
    end
  end

  assign rd_full  = {pred_r, pos};
  assign bk_ra    = rd_full[AW-1:0];
  assign issue    = (state_r == ST_RUN);
  assign res_k    = nib_res(nib_r, k_r, shift_r);
  assign mac_base = {{(ACC_W-SMP_W){res_k[SMP_W-1]}}, res_k} <<< FRAC_W;

  assign out_free = !out_vld_r || out_ready;
  assign fin_go   = (state_r == ST_FIN) && !ctl_d1_r.vld && !mac_busy && out_free;
  assign dec      = sat16(mac_acc[ACC_W-1:FRAC_W]);

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    t_nxt        = t_r;
    pred_nxt     = pred_r;
    shift_nxt    = shift_r;
    nib_nxt      = nib_r;
    err_nxt      = err_r;
    h0_nxt       = h0_r;
    h1_nxt       = h1_r;
    dec6_nxt     = dec6_r;
    out_wr       = 1'b0;
    out_smp_nxt  = out_smp_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (cmd == CMD_DECODE)) begin
          nib_nxt   = frame_nibbles;
          pred_nxt  = frame_header[3:0];
          shift_nxt = hdr_shift;
          k_nxt     = 4'd0;
          t_nxt     = 4'd0;
          if (sample_format == FMT_RAW) begin
            err_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end else if (bad_pred) begin
            err_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_RUN;
            if (first_frame) begin
              h0_nxt = '0;
              h1_nxt = '0;
            end
          end
        end
      end
      ST_RUN: begin
        t_nxt = t_r + 4'd1;
        if (t_r == t_last) begin
          t_nxt     = 4'd0;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_wr       = 1'b1;
          out_smp_nxt  = dec;
          out_last_nxt = (k_r == 4'd15);
          out_err_nxt  = 1'b0;
          if (i == 3'd6) begin
            dec6_nxt = dec;
          end
          if (i == 3'd7) begin
            h0_nxt = dec6_r;
            h1_nxt = dec;
          end
          if (k_r == 4'd15) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_wr       = 1'b1;
          out_smp_nxt  = err_r ? '0 : nib_r[SMP_W-1:0];
          out_last_nxt = 1'b1;
          out_err_nxt  = err_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_vld_nxt = out_wr ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      k_r       <= '0;
      t_r       <= '0;
      h0_r      <= '0;
      h1_r      <= '0;
      out_vld_r <= 1'b0;
      ctl_d1_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      t_r       <= t_nxt;
      h0_r      <= h0_nxt;
      h1_r      <= h1_nxt;
      out_vld_r <= out_vld_nxt;
      ctl_d1_r  <= '{vld: issue, first: (t_r == 4'd0)};
    end
  end

  always_ff @(posedge clk) begin
    pred_r     <= pred_nxt;
    shift_r    <= shift_nxt;
    nib_r      <= nib_nxt;
    err_r      <= err_nxt;
    dec6_r     <= dec6_nxt;
    out_smp_r  <= out_smp_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    opnd_d1_r  <= opnd;
  end

  // coefficient book: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (bk_we) begin
      book[bk_wa] <= coef_value;
    end
    if (issue) begin
      coef_rd_r <= book[bk_ra];
    end
  end

  assign mac_ctl    = ctl_d1_r;
  assign mac_coef   = coef_rd_r;
  assign mac_opnd   = opnd_d1_r;
  assign out_valid  = out_vld_r;
  assign out_sample = out_smp_r;
  assign out_last   = out_last_r;
  assign out_error  = out_err_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |-> out_free)
    else $error("result register overwritten while still pending");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_err_r) |-> (out_smp_r == '0 && out_last_r))
    else $error("error result must be a zero sample marked last");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && k_r == 4'd15) |=> (state_r == ST_IDLE && out_vld_r && out_last_r))
    else $error("final sample of a frame not marked last");

  a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |-> !$past(issue))
    else $error("sample finished with a term still in flight");

endmodule

`default_nettype wire

>>> sv/vector_adpcm_frame_decoder_top.sv
// Vector-ADPCM frame decoder. Load item: writes at most one book entry, no result. Raw or
// bad-predictor item: one result, registered from the emit state. ADPCM frame: sample i of a
// group issues i+2 terms through the single 16x16 MAC and waits for them to drain before its
// result is registered; output stalls hold each sample until it is taken.
// Ready only between items. rst_n (sync) clears config, history and control; the
// coefficient book is not cleared and must be loaded before use.
`default_nettype none

module vector_adpcm_frame_decoder_top #(
  parameter int MAX_PREDICTORS = vadpcm_pkg::MAX_PRED_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [7:0] frame_header, [71:8] frame_nibbles, [79:72] coef_index, [95:80] coef_value
  input  wire  [95:0] in_tdata,
  // [0] cmd, [1] first_frame
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] sample
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // [0] error
  output logic        out_tuser,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [vadpcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [vadpcm_pkg::CNT_W-1:0]     cfg_data
);
  import vadpcm_pkg::*;

  logic             fmt_r, fmt_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic             cfg_acc;

  mac_ctl_t                mac_ctl;
  logic signed [15:0]      mac_coef;
  logic signed [15:0]      mac_opnd;
  logic signed [ACC_W-1:0] mac_base;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_busy;
  logic signed [15:0]      out_sample;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    fmt_nxt  = fmt_r;
    pcnt_nxt = pcnt_r;
    if (cfg_acc) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT:   fmt_nxt  = cfg_data[0];
        REG_PREDICTOR_COUNT: pcnt_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_ADPCM;
      pcnt_r <= CNT_W'(1);
    end else begin
      fmt_r  <= fmt_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  vadpcm_seq #(
    .MAX_PREDICTORS(MAX_PREDICTORS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_format   (fmt_r),
    .predictor_count (pcnt_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .cmd             (in_tuser[0]),
    .first_frame     (in_tuser[1]),
    .frame_header    (in_tdata[7:0]),
    .frame_nibbles   (in_tdata[71:8]),
    .coef_index      (in_tdata[79:72]),
    .coef_value      (in_tdata[95:80]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_sample      (out_sample),
    .out_last        (out_tlast),
    .out_error       (out_tuser),
    .mac_ctl         (mac_ctl),
    .mac_coef        (mac_coef),
    .mac_opnd        (mac_opnd),
    .mac_base        (mac_base),
    .mac_acc         (mac_acc),
    .mac_busy        (mac_busy)
  );

  vadpcm_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .opnd  (mac_opnd),
    .base  (mac_base),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

  assign out_tdata = out_sample;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_adpcm_frame_decoder_top: book loads, ADPCM frames,
// raw passthrough and bad-predictor errors against an in-bench decoder; uses vadpcm_pkg.
// Directed table first, then random phases, the first four with sender/receiver backpressure.

module tb;
  import vadpcm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 50;
  localparam int IDLE_SETTLE = 8;      // quiet margin before a register write
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic        cmd;
    logic        first;
    logic [7:0]  hdr;
    logic [63:0] nibs;
    logic [7:0]  cidx;
    logic [15:0] cval;
  } stim_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        err;
  } sample_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CNT_W-1:0]      reg_data;
    stim_t                 s;
    logic                  typed;
    logic [15:0]           exp_sample;
    logic                  exp_err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  vector_adpcm_frame_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder mirror
  logic                fmt_q = FMT_ADPCM;
  logic [CNT_W-1:0]    count_q = 5'd1;
  logic signed [15:0]  coef_book [256];
  logic [255:0]        book_written = '0;
  logic signed [15:0]  hist0 = '0;
  logic signed [15:0]  hist1 = '0;

  sample_t pending_samples [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      snd_idle_pct = 0;
  int      rcv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // expected samples of one accepted item; updates the mirrored book and history
  task automatic predict_samples(input stim_t s);
    int unsigned        pred;
    int unsigned        shift;
    int unsigned        lim;
    int unsigned        base;
    int unsigned        k;
    logic [3:0]         nib;
    longint             acc;
    longint             res [8];
    logic signed [15:0] dec [8];
    if (s.cmd == CMD_LOAD) begin
      coef_book[s.cidx] = s.cval;
      book_written[s.cidx] = 1'b1;
      return;
    end
    if (fmt_q == FMT_RAW) begin
      pending_samples.push_back('{s.nibs[15:0], 1'b1, 1'b0});
      return;
    end
    lim = (count_q > MAX_PRED_DEF) ? MAX_PRED_DEF : count_q;
    pred = s.hdr[3:0];
    shift = s.hdr[7:4];
    if (pred >= lim) begin
      pending_samples.push_back('{16'h0000, 1'b1, 1'b1});
      return;
    end
    if (shift > SHIFT_MAX) shift = SHIFT_MAX;
    if (s.first) begin
      hist0 = '0;
      hist1 = '0;
    end
    base = pred * 16;
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 8; i++) begin
        k = g * 8 + i;
        nib = s.nibs[63 - 4 * k -: 4];
        res[i] = longint'($signed(nib)) <<< shift;
        acc = res[i] * 2048 + longint'(coef_book[base + i]) * hist0
              + longint'(coef_book[base + 8 + i]) * hist1;
        for (int j = 0; j < i; j++)
          acc += longint'(coef_book[base + 8 + (i - j - 1)]) * res[j];
        acc = acc >>> FRAC_W;   // floor division by 2048
        if (acc < -32768) dec[i] = 16'sh8000;
        else if (acc > 32767) dec[i] = 16'sh7FFF;
        else dec[i] = acc[15:0];
        pending_samples.push_back('{dec[i], k == 15, 1'b0});
      end
      hist0 = dec[6];
      hist1 = dec[7];
    end
  endtask

  task automatic send_item(input stim_t s, input logic typed, input logic [15:0] t_sample,
                           input logic t_err);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.cval, s.cidx, s.nibs, s.hdr};
    in_tuser  <= {s.first, s.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) pending_samples.push_back('{t_sample, 1'b1, t_err});
    else predict_samples(s);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SAMPLE_FORMAT) fmt_q = data[0];
    else if (idx == REG_PREDICTOR_COUNT) count_q = data;
  endtask

  function automatic dir_row_t row_item(input logic cmd, input logic first,
                                        input logic [7:0] hdr, input logic [63:0] nibs,
                                        input logic [7:0] cidx, input logic [15:0] cval,
                                        input logic typed, input logic [15:0] exp_s,
                                        input logic exp_e);
    dir_row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.s = '{cmd, first, hdr, nibs, cidx, cval};
    r.typed = typed;
    r.exp_sample = exp_s;
    r.exp_err = exp_e;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CNT_W-1:0] data);
    dir_row_t r;
    r = row_item(CMD_LOAD, 1'b0, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  always @(posedge clk) begin : check_out
    sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected item sample=%h last=%b err=%b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        want = pending_samples.pop_front();
        if (out_tdata !== want.sample)
          report_mismatch($sformatf("sample %h, expected %h", out_tdata, want.sample));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
        if (out_tuser !== want.err)
          report_mismatch($sformatf("error %b, expected %b", out_tuser, want.err));
      end
    end
  end

  initial begin
    dir_row_t   dir_rows [$];
    stim_t      s;
    stim_t      ld;
    logic       new_fmt;
    logic [4:0] new_cnt;
    int         lim;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 30;
    rcv_idle_pct = 69;

    // predictor 0: h0 row at the positive limit, the h1 and residual row at the negative one
    for (int pos = 0; pos < 16; pos++) begin
      ld = '0;
      ld.cmd = CMD_LOAD;
      ld.cidx = 8'(pos);
      ld.cval = (pos < 8) ? 16'h7FFF : 16'h8000;
      send_item(ld, 1'b0, '0, 1'b0);
    end

    // count is 1 after reset, so predictor 1 is out of range
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h01, 64'h0123_4567_89AB_CDEF, 8'h00,
                                16'h0000, 1'b1, 16'h0000, 1'b1));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'h00, {16{4'h7}}, 8'h00, 16'h0000,
                                1'b0, '0, 1'b0));
    // shift 15 is capped to 12
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'hF0, {16{4'h8}}, 8'hFF, 16'hFFFF,
                                1'b0, '0, 1'b0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'hC0, 64'h0123_4567_89AB_CDEF, 8'h00,
                                16'h0000, 1'b0, '0, 1'b0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h50, 64'hFEDC_BA98_7654_3210, 8'h00,
                                16'h0000, 1'b0, '0, 1'b0));
    dir_rows.push_back(row_item(CMD_LOAD, 1'b0, 8'h00, '0, 8'hFF, 16'h7FFF, 1'b0, '0, 1'b0));
    dir_rows.push_back(row_item(CMD_LOAD, 1'b1, 8'hFF, '1, 8'h00, 16'h8000, 1'b0, '0, 1'b0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'hC0, '1, 8'h00, 16'h0000, 1'b0, '0, 1'b0));
    // zero count: every frame is an error
    dir_rows.push_back(row_cfg(REG_PREDICTOR_COUNT, 5'd0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'h00, '1, 8'h00, 16'h0000,
                                1'b1, 16'h0000, 1'b1));
    // count above the book size acts as the book size
    dir_rows.push_back(row_cfg(REG_PREDICTOR_COUNT, 5'd31));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h30, '0, 8'h00, 16'h0000, 1'b0, '0, 1'b0));
    // write to a nonexistent register must not touch the count
    dir_rows.push_back(row_cfg(REG_UNUSED, 5'd0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h00, 64'h1, 8'h00, 16'h0000,
                                1'b0, '0, 1'b0));
    dir_rows.push_back(row_cfg(REG_SAMPLE_FORMAT, CNT_W'(FMT_RAW)));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_8000, 8'h00,
                                16'h0000, 1'b1, 16'h8000, 1'b0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h00, 64'h0000_0000_0000_7FFF, 8'h00,
                                16'h0000, 1'b1, 16'h7FFF, 1'b0));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h0F, 64'h0, 8'h00, 16'h0000,
                                1'b1, 16'h0000, 1'b0));
    dir_rows.push_back(row_item(CMD_LOAD, 1'b0, 8'h00, '0, 8'h01, 16'h0000, 1'b0, '0, 1'b0));
    // back to ADPCM: history must have survived the raw items
    dir_rows.push_back(row_cfg(REG_SAMPLE_FORMAT, CNT_W'(FMT_ADPCM)));
    dir_rows.push_back(row_cfg(REG_PREDICTOR_COUNT, 5'd16));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b0, 8'h20, 64'h8000_0000_0000_0007, 8'h00,
                                16'h0000, 1'b0, '0, 1'b0));
    dir_rows.push_back(row_cfg(REG_PREDICTOR_COUNT, 5'd1));
    dir_rows.push_back(row_item(CMD_DECODE, 1'b1, 8'hFF, '1, 8'h00, 16'h0000,
                                1'b1, 16'h0000, 1'b1));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
      else send_item(dir_rows[r].s, dir_rows[r].typed, dir_rows[r].exp_sample,
                     dir_rows[r].exp_err);
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          snd_idle_pct = 30;
          rcv_idle_pct = 69;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_idle_pct = 30;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      new_fmt = FMT_ADPCM;
      case (phase)
        0: new_cnt = 5'd16;
        1: new_cnt = 5'd1;
        2: begin
          new_fmt = FMT_RAW;
          new_cnt = 5'($urandom_range(1, 16));
        end
        3: new_cnt = 5'($urandom_range(2, 15));
        4: new_cnt = 5'd31;
        default: new_cnt = 5'($urandom_range(0, 31));
      endcase
      write_reg(REG_SAMPLE_FORMAT, CNT_W'(new_fmt));
      write_reg(REG_PREDICTOR_COUNT, new_cnt);

      for (int n = 0; n < 12; n++) begin
        s.cmd = CMD_DECODE;
        s.first = ($urandom_range(99) < 20);
        s.hdr = 8'($urandom);
        s.nibs = {$urandom, $urandom};
        s.cidx = 8'($urandom);
        s.cval = 16'($urandom);
        if ($urandom_range(99) < 15) begin
          s.cmd = CMD_LOAD;
        end else if (fmt_q == FMT_ADPCM) begin
          lim = (count_q > MAX_PRED_DEF) ? MAX_PRED_DEF : count_q;
          if (lim != 0 && $urandom_range(99) < 80) s.hdr[3:0] = 4'($urandom_range(lim - 1));
          // usable predictors are kept to 0, 5, 10 and 15 so few book entries need loading
          if (s.hdr[3:0] < lim) s.hdr[3:0] = 4'((s.hdr[3:0] / 5) * 5);
          // the book entry of a usable predictor is filled before its first frame
          if (s.hdr[3:0] < lim && !(&book_written[{s.hdr[3:0], 4'h0} +: 16])) begin
            for (int pos = 0; pos < 16; pos++) begin
              ld = '0;
              ld.cmd = CMD_LOAD;
              ld.cidx = {s.hdr[3:0], 4'(pos)};
              ld.cval = $urandom_range(1) ? 16'($urandom)
                                          : 16'($urandom_range(8191) - 4096);
              send_item(ld, 1'b0, '0, 1'b0);
            end
          end
          if ($urandom_range(9) == 0) s.nibs = $urandom_range(1) ? {16{4'h8}} : {16{4'h7}};
        end
        send_item(s, 1'b0, '0, 1'b0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/vadpcm_pkg.sv
sv/vadpcm_mac.sv
sv/vadpcm_seq.sv
sv/vector_adpcm_frame_decoder_top.sv
tb/tb.sv
